// ----- sv/fld_pkg.sv -----
// ----------------------------------------------------------------------------
// fld_pkg
// Shared types and constants of the field line doubler.
// ----------------------------------------------------------------------------
`default_nettype none

package fld_pkg;

  localparam int PIX_W      = 8;
  localparam int OUT_ROW_W  = 12;
  localparam int OUT_COL_W  = 13;
  localparam int LB_REG_W   = 14;
  localparam int LN_REG_W   = 12;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 14;
  localparam int OUT_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] REG_FIELD_PARITY = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_FRAME   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_BYTES   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_LINES  = 4'd3;

  // result slots of one kept byte: row above, own row, row below
  typedef enum logic [1:0] {
    SLOT_A,
    SLOT_B,
    SLOT_C
  } slot_t;

  typedef struct packed {
    logic [PIX_W-1:0]     pix;
    logic [OUT_COL_W-1:0] col;
    logic [OUT_ROW_W-1:0] row_base;   // 2j, masked
    logic                 parity;
    logic                 j_first;
    logic                 j_last;
  } item_t;

endpackage

`default_nettype wire

// ----- sv/fld_line_store.sv -----
// ----------------------------------------------------------------------------
// fld_line_store
// Line store: one byte per column, read-first, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fld_line_store #(
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [fld_pkg::PIX_W-1:0] wdata,
  output logic      [fld_pkg::PIX_W-1:0] rdata
);
  import fld_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rdata_r;

  // read sees the old byte when the same column is written at this edge
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[addr];
    end
    if (wr_en) begin
      mem[addr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- sv/fld_seq.sv -----
// ----------------------------------------------------------------------------
// fld_seq
// Configuration registers, column/row counters and kept-row decode.
// ----------------------------------------------------------------------------
`default_nettype none

module fld_seq #(
  parameter int MAX_LINE_BYTES = 8192,
  parameter int MAX_LINES      = 2048
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [fld_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [fld_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              in_accept,
  input  wire logic [fld_pkg::PIX_W-1:0]         in_pixel,
  output logic                                   kept,
  output logic [$clog2(MAX_LINE_BYTES)-1:0]      addr,
  output fld_pkg::item_t                         item
);
  import fld_pkg::*;

  localparam int CW   = $clog2(MAX_LINE_BYTES);
  localparam int RW   = $clog2(MAX_LINES);
  localparam int LBW  = (CW + 1 > LB_REG_W) ? CW + 1 : LB_REG_W;
  localparam int LNW  = (RW + 1 > LN_REG_W) ? RW + 1 : LN_REG_W;
  localparam int ORW  = (RW + 1 > OUT_ROW_W) ? RW + 1 : OUT_ROW_W;
  localparam int OCW  = (CW > OUT_COL_W) ? CW : OUT_COL_W;
  localparam int RESET_LB = (8192 > MAX_LINE_BYTES) ? MAX_LINE_BYTES : 8192;
  localparam int RESET_LN = (240 > MAX_LINES) ? MAX_LINES : 240;

  logic          parity_r, parity_nxt;
  logic          full_r, full_nxt;
  logic [CW:0]   eff_lb_r, eff_lb_nxt;
  logic [RW:0]   eff_ln_r, eff_ln_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;

  logic [LBW-1:0] lb_ext;
  logic [LNW-1:0] ln_ext;
  logic [CW-1:0]  col_c;
  logic [RW-1:0]  row_c;
  logic [RW-1:0]  j;
  logic [RW:0]    fcount;
  logic [RW:0]    pair_lim;
  logic [CW:0]    col_inc;
  logic [RW:0]    row_inc;
  logic [ORW-1:0] base_x;
  logic [OCW-1:0] col_x;

  assign cfg_ready = 1'b1;

  // saturated register values, zero treated as one
  always_comb begin
    lb_ext = LBW'(cfg_data[LB_REG_W-1:0]);
    ln_ext = LNW'(cfg_data[LN_REG_W-1:0]);
    if (lb_ext == '0) begin
      lb_ext = LBW'(1);
    end else if (lb_ext > LBW'(MAX_LINE_BYTES)) begin
      lb_ext = LBW'(MAX_LINE_BYTES);
    end
    if (ln_ext == '0) begin
      ln_ext = LNW'(1);
    end else if (ln_ext > LNW'(MAX_LINES)) begin
      ln_ext = LNW'(MAX_LINES);
    end
  end

  always_comb begin
    col_c = ({1'b0, col_r} >= eff_lb_r) ? '0 : col_r;
    row_c = ({1'b0, row_r} >= eff_ln_r) ? '0 : row_r;
    pair_lim = {eff_ln_r[RW:1], 1'b0};
    if (full_r) begin
      kept   = (row_c[0] == parity_r) && ({1'b0, row_c} < pair_lim);
      j      = row_c >> 1;
      fcount = eff_ln_r >> 1;
    end else begin
      kept   = 1'b1;
      j      = row_c;
      fcount = eff_ln_r;
    end
    base_x = ORW'(j) << 1;
    col_x  = OCW'(col_c);
    item.pix      = in_pixel;
    item.col      = col_x[OUT_COL_W-1:0];
    item.row_base = base_x[OUT_ROW_W-1:0];
    item.parity   = parity_r;
    item.j_first  = (j == '0);
    item.j_last   = ((RW+1)'(j) + (RW+1)'(1)) == fcount;
    addr = col_c;
  end

  always_comb begin
    parity_nxt = parity_r;
    full_nxt   = full_r;
    eff_lb_nxt = eff_lb_r;
    eff_ln_nxt = eff_ln_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    col_inc    = {1'b0, col_c} + (CW+1)'(1);
    row_inc    = {1'b0, row_c} + (RW+1)'(1);
    if (in_accept) begin
      if (col_inc >= eff_lb_r) begin
        col_nxt = '0;
        row_nxt = (row_inc >= eff_ln_r) ? '0 : row_inc[RW-1:0];
      end else begin
        col_nxt = col_inc[CW-1:0];
        row_nxt = row_c;
      end
    end
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_FIELD_PARITY: begin
          parity_nxt = cfg_data[0];
          col_nxt = '0;
          row_nxt = '0;
        end
        REG_FULL_FRAME: begin
          full_nxt = cfg_data[0];
          col_nxt = '0;
          row_nxt = '0;
        end
        REG_LINE_BYTES: begin
          eff_lb_nxt = lb_ext[CW:0];
          col_nxt = '0;
          row_nxt = '0;
        end
        REG_INPUT_LINES: begin
          eff_ln_nxt = ln_ext[RW:0];
          col_nxt = '0;
          row_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parity_r <= 1'b0;
      full_r   <= 1'b0;
      eff_lb_r <= (CW+1)'(RESET_LB);
      eff_ln_r <= (RW+1)'(RESET_LN);
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      parity_r <= parity_nxt;
      full_r   <= full_nxt;
      eff_lb_r <= eff_lb_nxt;
      eff_ln_r <= eff_ln_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/fld_emit.sv -----
// ----------------------------------------------------------------------------
// fld_emit
// Holds one kept byte with its stored neighbour and sends its results
// one per cycle, unless out_tready stalls the output, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fld_emit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            load,       // kept byte accepted
  input  wire fld_pkg::item_t                  load_item,
  input  wire logic [fld_pkg::PIX_W-1:0]       prev_pix,   // aligned with held byte
  output logic                                 free,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [fld_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic                                 out_tlast
);
  import fld_pkg::*;

  logic  hold_valid_r, hold_valid_nxt;
  item_t hold_r;
  slot_t slot_r, slot_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]     val_r;
  logic [OUT_ROW_W-1:0] row_r;
  logic [OUT_COL_W-1:0] col_r;
  logic                 last_r;

  logic                 out_load;
  logic                 has_c;
  logic [PIX_W:0]       sum;
  logic [PIX_W-1:0]     avg;
  logic [PIX_W-1:0]     cur_val;
  logic [OUT_ROW_W-1:0] cur_row;
  logic                 cur_last;

  assign sum   = {1'b0, prev_pix} + {1'b0, hold_r.pix};
  assign avg   = sum[PIX_W:1];
  assign has_c = hold_r.parity || hold_r.j_last;

  always_comb begin
    out_load = hold_valid_r && (!out_valid_r || out_tready);
    unique case (slot_r)
      SLOT_A: begin
        cur_val  = avg;
        cur_row  = hold_r.row_base - OUT_ROW_W'(1);
        cur_last = 1'b0;
      end
      SLOT_B: begin
        cur_val  = (!hold_r.parity || hold_r.j_first) ? hold_r.pix : avg;
        cur_row  = hold_r.row_base;
        cur_last = !has_c;
      end
      SLOT_C: begin
        cur_val  = hold_r.pix;
        cur_row  = hold_r.row_base + OUT_ROW_W'(1);
        cur_last = 1'b1;
      end
      default: begin
        cur_val  = hold_r.pix;
        cur_row  = hold_r.row_base;
        cur_last = 1'b1;
      end
    endcase
    free = !hold_valid_r || (out_load && cur_last);

    hold_valid_nxt = hold_valid_r;
    slot_nxt       = slot_r;
    if (out_load) begin
      unique case (slot_r)
        SLOT_A:  slot_nxt = SLOT_B;
        SLOT_B:  slot_nxt = SLOT_C;
        default: slot_nxt = slot_r;
      endcase
      if (cur_last) begin
        hold_valid_nxt = 1'b0;
      end
    end
    if (load) begin
      hold_valid_nxt = 1'b1;
      slot_nxt = (!load_item.parity && !load_item.j_first) ? SLOT_A : SLOT_B;
    end

    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      slot_r       <= SLOT_B;
      out_valid_r  <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      slot_r       <= slot_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold_r <= load_item;
    end
    if (out_load) begin
      val_r  <= cur_val;
      row_r  <= cur_row;
      col_r  <= hold_r.col;
      last_r <= cur_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {{(OUT_DATA_W - PIX_W - OUT_ROW_W - OUT_COL_W){1'b0}},
                       col_r, row_r, val_r};

endmodule

`default_nettype wire

// ----- sv/field_line_doubler_unit.sv -----
// ----------------------------------------------------------------------------
// field_line_doubler_unit
// Bob deinterlacer: doubles a field into a frame, missing rows averaged
// from the kept rows above and below through a one-line store.
// ----------------------------------------------------------------------------
//  channel  direction  payload
//  in_      slave      tdata[7:0] pixel
//  out_     master     tdata value/row/col, tlast = last result of the byte
//  cfg_     slave      index 0 parity, 1 full frame, 2 line bytes, 3 lines
//
//  a kept byte gives two results (with even parity one on the top row and
//  three on the bottom row) and sends one result per cycle to the output
//  register unless out_tready stalls it; dropped bytes of a full frame give no results
//  results pass the hold register and then the output register
//  line store read and write share the column address in the accept cycle
//  no clearing after reset; a write to registers 0 to 3 restarts the picture
// ----------------------------------------------------------------------------
`default_nettype none

module field_line_doubler_unit #(
  parameter int MAX_LINE_BYTES = 8192,
  parameter int MAX_LINES      = 2048
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [7:0]                       in_tdata,   // pixel[7:0]
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // value[7:0], out_row[19:8], out_col[32:20], zero[39:33]
  output logic [fld_pkg::OUT_DATA_W-1:0]        out_tdata,
  output logic                                  out_tlast,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [fld_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [fld_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import fld_pkg::*;

  localparam int CW = $clog2(MAX_LINE_BYTES);

  logic          in_accept;
  logic          kept;
  logic          free;
  logic [CW-1:0] addr;
  item_t         item;
  logic [PIX_W-1:0] prev_pix;

  assign in_tready = free;
  assign in_accept = in_tvalid && in_tready;

  fld_seq #(
    .MAX_LINE_BYTES (MAX_LINE_BYTES),
    .MAX_LINES      (MAX_LINES)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_accept (in_accept),
    .in_pixel  (in_tdata),
    .kept      (kept),
    .addr      (addr),
    .item      (item)
  );

  fld_line_store #(
    .DEPTH (MAX_LINE_BYTES)
  ) u_store (
    .clk   (clk),
    .rd_en (in_accept && kept),
    .wr_en (in_accept && kept),
    .addr  (addr),
    .wdata (in_tdata),
    .rdata (prev_pix)
  );

  fld_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_accept && kept),
    .load_item  (item),
    .prev_pix   (prev_pix),
    .free       (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ----- sv/fld_checker.sv -----
// ----------------------------------------------------------------------------
// fld_checker
// Port-level checks of the field line doubler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fld_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic        out_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // the rest of a byte's results follows without a gap
  a_run_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap inside the results of one byte");

  a_run_same_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tdata[32:20] == $past(out_tdata[32:20]))
    else $error("column changed inside the results of one byte");

endmodule

bind field_line_doubler_unit fld_checker u_fld_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
